// ===== hdl/vca_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vca_pkg: shared types and constants of the value category assigner
// Transaction payload types, sequencer states, reserved key patterns and
// configuration register decode.
// ----------------------------------------------------------------------------
package vca_pkg;

  // Operation codes of an input transaction.
  localparam logic OP_CLASSIFY = 1'b0;
  localparam logic OP_CLEAR    = 1'b1;

  // Reserved key patterns: both zeros map to category 0, exactly 1.0 to category 1.
  localparam logic [63:0] BITS_POS_ZERO = 64'h0000_0000_0000_0000;
  localparam logic [63:0] BITS_NEG_ZERO = 64'h8000_0000_0000_0000;
  localparam logic [63:0] BITS_ONE      = 64'h3FF0_0000_0000_0000;

  // Reserved category numbers and the first one handed out.
  localparam logic [3:0] CAT_ZERO   = 4'd0;
  localparam logic [3:0] CAT_ONE    = 4'd1;
  localparam int         FIRST_FREE = 2;

  // Configuration port: byte address width and register decode.
  localparam int         CFG_AW          = 3;
  localparam int         CFG_DW          = 32;
  localparam logic       REG_MAX_CAT     = 1'b0;
  localparam int         MAX_CAT_W       = 5;
  localparam logic [4:0] MAX_CAT_RESET   = 5'd16;

  // Input transaction payload.
  typedef struct packed {
    logic        op;
    logic [63:0] rate_bits;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [3:0] category;
    logic       is_new;
    logic       table_full;
  } out_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_INSERT
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/vca_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vca_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vca_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 14,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/vca_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vca_seq: lookup sequencer with one shared key comparator
// Resolves reserved keys, scans the stored keys one per cycle through the
// key RAM and the single 64-bit comparator, and appends new keys.
// ----------------------------------------------------------------------------
module vca_seq #(
  parameter int MAX_CATEGORY_LIMIT = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire vca_pkg::in_t                  in_data,
  input  wire logic [vca_pkg::MAX_CAT_W-1:0] max_cat,
  output logic                               busy,
  output logic                               out_valid,
  output vca_pkg::out_t                      out_data
);

  localparam int DEPTH  = MAX_CATEGORY_LIMIT - 2;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NF_RAW = $clog2(MAX_CATEGORY_LIMIT + 1);
  localparam int NF_W   = (NF_RAW > vca_pkg::MAX_CAT_W) ? NF_RAW : vca_pkg::MAX_CAT_W;

  vca_pkg::state_t   state_r, state_nxt;
  logic              op_r, op_nxt;
  logic [63:0]       key_r, key_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [NF_W-1:0]   next_free_r, next_free_nxt;
  logic              out_valid_r, out_valid_nxt;
  vca_pkg::out_t     out_data_r, out_data_nxt;

  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  logic              ram_rd_en;
  logic [IDX_W-1:0]  ram_rd_addr;
  logic [63:0]       ram_rd_data;

  logic              accept;
  logic              is_zero;
  logic              is_one;
  logic [NF_W-1:0]   used;
  logic              table_empty;
  logic              key_match;
  logic              scan_last;
  logic              no_room;
  logic [NF_W-1:0]   idx_cat;

  // Key storage: entry i holds the key of category i+2.
  vca_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH),
    .AW    (IDX_W)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (key_r),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Shared decode of the held transaction and the scan position.
  assign accept      = start && !busy;
  assign is_zero     = (key_r == vca_pkg::BITS_POS_ZERO) || (key_r == vca_pkg::BITS_NEG_ZERO);
  assign is_one      = (key_r == vca_pkg::BITS_ONE);
  assign used        = next_free_r - NF_W'(vca_pkg::FIRST_FREE);
  assign table_empty = (used == '0);
  assign key_match   = (ram_rd_data == key_r);
  assign scan_last   = ((NF_W'(idx_r) + NF_W'(1)) == used);
  assign idx_cat     = NF_W'(idx_r) + NF_W'(vca_pkg::FIRST_FREE);
  assign no_room     = (next_free_r >= NF_W'(max_cat)) ||
                       (next_free_r >= NF_W'(MAX_CATEGORY_LIMIT));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vca_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = vca_pkg::ST_CHECK;
        end
      end
      vca_pkg::ST_CHECK: begin
        if (op_r == vca_pkg::OP_CLEAR || is_zero || is_one) begin
          state_nxt = vca_pkg::ST_IDLE;
        end else if (table_empty) begin
          state_nxt = vca_pkg::ST_INSERT;
        end else begin
          state_nxt = vca_pkg::ST_SCAN;
        end
      end
      vca_pkg::ST_SCAN: begin
        if (key_match) begin
          state_nxt = vca_pkg::ST_IDLE;
        end else if (scan_last) begin
          state_nxt = vca_pkg::ST_INSERT;
        end
      end
      vca_pkg::ST_INSERT: begin
        state_nxt = vca_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = vca_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath, RAM control and result logic.
  always_comb begin
    op_nxt        = op_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    next_free_nxt = next_free_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = used[IDX_W-1:0];
    ram_rd_en     = 1'b0;
    ram_rd_addr   = idx_r + IDX_W'(1);
    case (state_r)
      vca_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt  = in_data.op;
          key_nxt = in_data.rate_bits;
        end
      end
      vca_pkg::ST_CHECK: begin
        // Reserved cases finish here; otherwise prefetch entry 0.
        idx_nxt     = '0;
        ram_rd_addr = '0;
        if (op_r == vca_pkg::OP_CLEAR) begin
          next_free_nxt = NF_W'(vca_pkg::FIRST_FREE);
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{category: vca_pkg::CAT_ZERO, is_new: 1'b0, table_full: 1'b0};
        end else if (is_zero) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{category: vca_pkg::CAT_ZERO, is_new: 1'b0, table_full: 1'b0};
        end else if (is_one) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{category: vca_pkg::CAT_ONE, is_new: 1'b0, table_full: 1'b0};
        end else if (!table_empty) begin
          ram_rd_en = 1'b1;
        end
      end
      vca_pkg::ST_SCAN: begin
        // Compare the entry read last cycle and fetch the following one.
        if (key_match) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{category: idx_cat[3:0], is_new: 1'b0, table_full: 1'b0};
        end else if (!scan_last) begin
          idx_nxt   = idx_r + IDX_W'(1);
          ram_rd_en = 1'b1;
        end
      end
      vca_pkg::ST_INSERT: begin
        out_valid_nxt = 1'b1;
        if (no_room) begin
          out_data_nxt = '{category: vca_pkg::CAT_ZERO, is_new: 1'b0, table_full: 1'b1};
        end else begin
          ram_wr_en     = 1'b1;
          next_free_nxt = next_free_r + NF_W'(1);
          out_data_nxt  = '{category: next_free_r[3:0], is_new: 1'b1, table_full: 1'b0};
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vca_pkg::ST_IDLE;
      next_free_r <= NF_W'(vca_pkg::FIRST_FREE);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != vca_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== hdl/value_category_assigner_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// value_category_assigner_top: double-pattern to category number dictionary
// Maps 64-bit double patterns to small persistent category numbers, with
// zero and one reserved, and holds the max_categories register.
//
//   Channel   Ports                              Handshake
//   input     start, busy, in_data               accepted when start && !busy
//   result    out_valid, out_data                one-cycle strobe, no stall
//   config    psel, penable, pwrite, paddr,      APB write and read, pready always high
//             pwdata, prdata, pready
//
// A reserved key or a clear is resolved in the check state, with no scan. Any
// other key scans the stored keys with one key RAM read and one comparison per
// cycle until it hits on the N-th stored key or misses all N stored keys (N up
// to MAX_CATEGORY_LIMIT-2); a miss then goes through the insert state.
// busy is high from acceptance until the result strobe; the next transaction
// may start in the strobe cycle. Reset empties the table and sets
// max_categories to 16. The result receiver cannot stall the block.
// ----------------------------------------------------------------------------
module value_category_assigner_top #(
  parameter int MAX_CATEGORY_LIMIT = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire vca_pkg::in_t                in_data,
  output logic                             out_valid,
  output vca_pkg::out_t                    out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [vca_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [vca_pkg::CFG_DW-1:0]  pwdata,
  output logic      [vca_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready
);

  logic [vca_pkg::MAX_CAT_W-1:0] max_cat_r, max_cat_nxt;
  logic                          cfg_wr;
  logic                          sel_max_cat;

  // Register decode: one word register at byte address 0.
  assign sel_max_cat = (paddr[vca_pkg::CFG_AW-1] == vca_pkg::REG_MAX_CAT);
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign pready      = 1'b1;

  always_comb begin
    max_cat_nxt = max_cat_r;
    if (cfg_wr && sel_max_cat) begin
      max_cat_nxt = pwdata[vca_pkg::MAX_CAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cat_r <= vca_pkg::MAX_CAT_RESET;
    end else begin
      max_cat_r <= max_cat_nxt;
    end
  end

  // Read-back of the configuration register.
  assign prdata = sel_max_cat ? vca_pkg::CFG_DW'(max_cat_r) : '0;

  // Lookup sequencer with the key store.
  vca_seq #(
    .MAX_CATEGORY_LIMIT (MAX_CATEGORY_LIMIT)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .max_cat   (max_cat_r),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for value_category_assigner_top
// Drives double bit patterns and clear commands through the start/busy port,
// with bursts and random gaps. It rewrites max_categories over APB between
// phases and checks every result strobe against a local model of the
// category dictionary.
// ----------------------------------------------------------------------------
module tb;

  localparam int CATEGORY_LIMIT  = 16;
  localparam int KEY_DEPTH       = CATEGORY_LIMIT - 2;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int POOL_MAX        = 24;
  localparam int SETTLE_CYCLES   = 24;
  localparam int CYCLE_LIMIT     = 500000;

  localparam logic [vca_pkg::CFG_AW-1:0] MAX_CAT_ADDR =
    vca_pkg::CFG_AW'(4 * int'(vca_pkg::REG_MAX_CAT));

  // Limits used by the first phases: both ends, the smallest usable table,
  // and a drop below what is already stored.
  localparam logic [vca_pkg::MAX_CAT_W-1:0] MAX_PLAN [6] =
    '{5'd2, 5'd3, 5'd16, 5'd4, 5'd15, 5'd9};

  // Results that can be read straight off the rules.
  localparam vca_pkg::out_t NO_WANT        = '0;
  localparam vca_pkg::out_t WANT_ZERO      = '{vca_pkg::CAT_ZERO, 1'b0, 1'b0};
  localparam vca_pkg::out_t WANT_ONE       = '{vca_pkg::CAT_ONE, 1'b0, 1'b0};
  localparam vca_pkg::out_t WANT_FIRST_NEW = '{4'(vca_pkg::FIRST_FREE), 1'b1, 1'b0};
  localparam vca_pkg::out_t WANT_FIRST_OLD = '{4'(vca_pkg::FIRST_FREE), 1'b0, 1'b0};
  localparam vca_pkg::out_t WANT_FULL      = '{vca_pkg::CAT_ZERO, 1'b0, 1'b1};

  typedef struct packed {
    logic          op;
    logic [63:0]   rate_bits;
    logic          has_want;
    vca_pkg::out_t want;
  } dir_row_t;

  // Directed rows, run right after reset with max_categories at 16.
  dir_row_t directed_rows [23] = '{
    '{vca_pkg::OP_CLASSIFY, vca_pkg::BITS_POS_ZERO,   1'b1, WANT_ZERO},
    '{vca_pkg::OP_CLASSIFY, vca_pkg::BITS_NEG_ZERO,   1'b1, WANT_ZERO},
    '{vca_pkg::OP_CLASSIFY, vca_pkg::BITS_ONE,        1'b1, WANT_ONE},
    '{vca_pkg::OP_CLASSIFY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, WANT_FIRST_NEW},
    '{vca_pkg::OP_CLASSIFY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, WANT_FIRST_OLD},
    '{vca_pkg::OP_CLASSIFY, 64'h7FF8_0000_0000_0000, 1'b0, NO_WANT},
    '{vca_pkg::OP_CLASSIFY, 64'h0000_0000_0000_0001, 1'b0, NO_WANT},
    '{vca_pkg::OP_CLASSIFY, 64'h3FF0_0000_0000_0001, 1'b0, NO_WANT},
    '{vca_pkg::OP_CLASSIFY, 64'hBFF0_0000_0000_0000, 1'b0, NO_WANT},
    '{vca_pkg::OP_CLASSIFY, 64'h7FF0_0000_0000_0000, 1'b0, NO_WANT},
    '{vca_pkg::OP_CLASSIFY, 64'hFFF0_0000_0000_0000, 1'b0, NO_WANT},
    '{vca_pkg::OP_CLASSIFY, 64'h7FF8_0000_0000_0000, 1'b0, NO_WANT},
    '{vca_pkg::OP_CLASSIFY, 64'h8000_0000_0000_0001, 1'b0, NO_WANT},
    '{vca_pkg::OP_CLASSIFY, 64'h3FEF_FFFF_FFFF_FFFF, 1'b0, NO_WANT},
    '{vca_pkg::OP_CLASSIFY, 64'h0010_0000_0000_0000, 1'b0, NO_WANT},
    '{vca_pkg::OP_CLASSIFY, 64'h7FEF_FFFF_FFFF_FFFF, 1'b0, NO_WANT},
    '{vca_pkg::OP_CLASSIFY, 64'h4000_0000_0000_0000, 1'b0, NO_WANT},
    '{vca_pkg::OP_CLASSIFY, 64'hC000_0000_0000_0000, 1'b0, NO_WANT},
    '{vca_pkg::OP_CLASSIFY, 64'h5555_5555_5555_5555, 1'b0, NO_WANT},
    '{vca_pkg::OP_CLASSIFY, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, WANT_FULL},
    '{vca_pkg::OP_CLASSIFY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, WANT_FIRST_OLD},
    '{vca_pkg::OP_CLEAR,    64'h0123_4567_89AB_CDEF, 1'b1, WANT_ZERO},
    '{vca_pkg::OP_CLASSIFY, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, WANT_FIRST_NEW}
  };

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  vca_pkg::in_t               in_data;
  logic                       out_valid;
  vca_pkg::out_t              out_data;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [vca_pkg::CFG_AW-1:0] paddr;
  logic [vca_pkg::CFG_DW-1:0] pwdata;
  logic [vca_pkg::CFG_DW-1:0] prdata;
  logic                       pready;

  // Local copy of the dictionary state and the register.
  logic [63:0]                   seen_keys [KEY_DEPTH];
  int                            free_category;
  logic [vca_pkg::MAX_CAT_W-1:0] max_categories_reg;

  vca_pkg::out_t pending_categories [$];
  vca_pkg::out_t oldest_expected;
  logic [63:0]   key_pool [POOL_MAX];
  int            error_count = 0;
  int unsigned   cycle_count = 0;

  value_category_assigner_top #(
    .MAX_CATEGORY_LIMIT(CATEGORY_LIMIT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Clock and cycle counter.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Work out the category the block should hand back, updating the local table.
  function automatic vca_pkg::out_t assign_category(input vca_pkg::in_t item);
    vca_pkg::out_t result;
    int            used;
    int            top;
    result = '0;
    if (item.op == vca_pkg::OP_CLEAR) begin
      free_category = vca_pkg::FIRST_FREE;
      return result;
    end
    if (item.rate_bits == vca_pkg::BITS_POS_ZERO ||
        item.rate_bits == vca_pkg::BITS_NEG_ZERO) begin
      result.category = vca_pkg::CAT_ZERO;
      return result;
    end
    if (item.rate_bits == vca_pkg::BITS_ONE) begin
      result.category = vca_pkg::CAT_ONE;
      return result;
    end
    used = free_category - vca_pkg::FIRST_FREE;
    if (used > KEY_DEPTH) used = KEY_DEPTH;
    for (int i = 0; i < used; i++) begin
      if (seen_keys[i] == item.rate_bits) begin
        result.category = 4'(i + vca_pkg::FIRST_FREE);
        return result;
      end
    end
    top = (int'(max_categories_reg) > CATEGORY_LIMIT) ? CATEGORY_LIMIT
                                                      : int'(max_categories_reg);
    if (free_category >= top || used >= KEY_DEPTH) begin
      result.table_full = 1'b1;
      return result;
    end
    seen_keys[used] = item.rate_bits;
    result.category = 4'(free_category);
    result.is_new   = 1'b1;
    free_category++;
    return result;
  endfunction

  // Present one transaction and hold it until the block takes it. start is
  // left high so a following transaction can go back to back.
  task automatic send_item(input vca_pkg::in_t item, input logic has_want,
                           input vca_pkg::out_t want);
    vca_pkg::out_t predicted;
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    predicted = assign_category(item);
    pending_categories.insert(pending_categories.size(), has_want ? want : predicted);
  endtask

  // Wait until every result is in, then let the block settle.
  task automatic drain_and_settle();
    while (pending_categories.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of max_categories followed by a read back.
  task automatic write_max_categories(input logic [vca_pkg::MAX_CAT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_CAT_ADDR;
    pwdata  <= vca_pkg::CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    max_categories_reg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[vca_pkg::MAX_CAT_W-1:0] !== value) begin
      $error("max_categories readback: expected %0d, actual %0d",
             value, prdata[vca_pkg::MAX_CAT_W-1:0]);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_categories.size() == 0) begin
        $error("unexpected result transaction: category %0d is_new %0b table_full %0b",
               out_data.category, out_data.is_new, out_data.table_full);
        error_count++;
      end else begin
        oldest_expected = pending_categories.pop_front();
        if (out_data.category !== oldest_expected.category) begin
          $error("category: expected %0d, actual %0d",
                 oldest_expected.category, out_data.category);
          error_count++;
        end
        if (out_data.is_new !== oldest_expected.is_new) begin
          $error("is_new: expected %0b, actual %0b",
                 oldest_expected.is_new, out_data.is_new);
          error_count++;
        end
        if (out_data.table_full !== oldest_expected.table_full) begin
          $error("table_full: expected %0b, actual %0b",
                 oldest_expected.table_full, out_data.table_full);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("value_category_assigner_top regression: fail");
    $finish;
  end

  // Stimulus.
  initial begin
    int                            pool_size;
    int                            burst_left;
    int                            pick;
    int                            gap;
    logic [63:0]                   reserved;
    vca_pkg::in_t                  item;
    logic [vca_pkg::MAX_CAT_W-1:0] limit;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    free_category      = vca_pkg::FIRST_FREE;
    max_categories_reg = vca_pkg::MAX_CAT_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // Directed table, with short random gaps between rows.
    foreach (directed_rows[r]) begin
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      item.op        = directed_rows[r].op;
      item.rate_bits = directed_rows[r].rate_bits;
      send_item(item, directed_rows[r].has_want, directed_rows[r].want);
    end
    start <= 1'b0;
    drain_and_settle();
    write_max_categories(vca_pkg::MAX_CAT_RESET);

    // Random phases, each with its own limit and pool of recurring keys.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_and_settle();
      if (phase < $size(MAX_PLAN)) limit = MAX_PLAN[phase];
      else limit = vca_pkg::MAX_CAT_W'($urandom_range(2, 16));
      write_max_categories(limit);

      pool_size = $urandom_range(2, POOL_MAX);
      for (int k = 0; k < pool_size; k++) key_pool[k] = {$urandom, $urandom};

      // Some phases start from an empty table; the others keep what is
      // stored, which covers a limit lowered below the keys in use.
      if (phase % 3 == 0) begin
        item.op        = vca_pkg::OP_CLEAR;
        item.rate_bits = {$urandom, $urandom};
        send_item(item, 1'b0, NO_WANT);
      end

      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Gap between bursts; a quarter of the gaps are zero.
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 24);
        end
        burst_left--;

        item.op = vca_pkg::OP_CLASSIFY;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          item.op        = vca_pkg::OP_CLEAR;
          item.rate_bits = {$urandom, $urandom};
        end else if (pick < 50) begin
          item.rate_bits = key_pool[$urandom_range(0, pool_size - 1)];
        end else if (pick < 70) begin
          item.rate_bits = {$urandom, $urandom};
        end else begin
          case ($urandom_range(0, 2))
            0:       reserved = vca_pkg::BITS_POS_ZERO;
            1:       reserved = vca_pkg::BITS_NEG_ZERO;
            default: reserved = vca_pkg::BITS_ONE;
          endcase
          if (pick < 80) begin
            item.rate_bits = reserved;
          end else if (pick < 90) begin
            // One bit away from a reserved pattern.
            item.rate_bits = reserved ^ (64'd1 << $urandom_range(0, 63));
          end else begin
            // NaN patterns with a few distinct payloads so repeats occur.
            item.rate_bits = {1'($urandom_range(0, 1)), 11'h7FF, 49'd0,
                              3'($urandom_range(1, 7))};
          end
        end
        send_item(item, 1'b0, NO_WANT);
      end
      start <= 1'b0;
    end

    drain_and_settle();
    if (error_count == 0) begin
      $display("value_category_assigner_top regression: pass");
    end else begin
      $display("value_category_assigner_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/vca_pkg.sv
hdl/vca_ram.sv
hdl/vca_seq.sv
hdl/value_category_assigner_top.sv
sim/tb.sv
